// File: design/lbt_pkg.sv
package lbt_pkg;

  localparam int TIME_WIDTH_DEF = 64;
  localparam int OFF_W = 42;
  localparam int DELAY_W = 36;
  localparam int SHIFT_W = 3;

  localparam logic [6:0] PCT_FULL = 7'd100;
  localparam logic [9:0] MS_PER_S = 10'd1000;
  localparam logic [3:0] PCT_SCALE = 4'd10;
  localparam logic [SHIFT_W-1:0] MAX_SHIFT = 3'd4;
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  localparam logic [6:0] RENEW_PCT_RST = 7'd45;
  localparam logic [31:0] RETRY_BASE_RST = 32'd30000;
  localparam logic [31:0] RETRY_CAP_RST = 32'd300000;

  localparam logic [1:0] REG_RENEW_PCT = 2'd0;
  localparam logic [1:0] REG_RETRY_BASE = 2'd1;
  localparam logic [1:0] REG_RETRY_CAP = 2'd2;

  typedef enum logic [1:0] {
    CMD_QUERY    = 2'd0,
    CMD_ACTIVATE = 2'd1,
    CMD_MARK     = 2'd2,
    CMD_CLEAR    = 2'd3
  } command_t;

  typedef struct packed {
    logic [6:0]  renew_percent;
    logic [31:0] retry_base_ms;
    logic [31:0] retry_cap_ms;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic mul_en;
    logic add_en;
    logic commit;
  } ctl_cmd_t;

endpackage

// File: design/lbt_ctrl.sv
module lbt_ctrl import lbt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_COMMIT
  } state_t;

  state_t state;
  logic   in_fire;
  logic   slot_free;

  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  assign cmd.capture = in_fire;
  assign cmd.mul_en  = (state == S_MUL);
  assign cmd.add_en  = (state == S_ADD);
  assign cmd.commit  = (state == S_COMMIT) && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            state    <= S_MUL;
            in_ready <= 1'b0;
          end
        end
        S_MUL: begin
          state <= S_ADD;
        end
        S_ADD: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (slot_free) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/lbt_datapath.sv
module lbt_datapath import lbt_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  ctl_cmd_t    cmd,
  input  cfg_t        cfg,
  input  logic [1:0]  command,
  input  logic [63:0] now_ms,
  input  logic [31:0] lease_life_s,
  output logic        attempt_due,
  output logic        lease_expired,
  output logic        lease_finite,
  output logic [63:0] next_attempt_time,
  output logic [63:0] expiry_time,
  output logic [7:0]  attempts_made
);

  localparam int SUM_W = ((TIME_WIDTH > OFF_W) ? TIME_WIDTH : OFF_W) + 1;
  localparam logic [TIME_WIDTH-1:0] TMAX = '1;

  function automatic logic [TIME_WIDTH-1:0] sat_add(input logic [TIME_WIDTH-1:0] a,
                                                     input logic [OFF_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    return (s > SUM_W'(TMAX)) ? TMAX : s[TIME_WIDTH-1:0];
  endfunction

  logic [1:0]            cmd_q;
  logic [TIME_WIDTH-1:0] now_q;
  logic [31:0]           life_q;

  logic [OFF_W-1:0]      life_ms;
  logic [OFF_W-1:0]      renew_off;
  logic [DELAY_W-1:0]    delay;
  logic [7:0]            cnt_inc;

  logic [TIME_WIDTH-1:0] renew_sum;
  logic [TIME_WIDTH-1:0] expire_sum;
  logic [TIME_WIDTH-1:0] try_sum;

  logic [TIME_WIDTH-1:0] expire_time;
  logic [TIME_WIDTH-1:0] next_try_time;
  logic [7:0]            try_count;
  logic                  is_finite;

  logic [TIME_WIDTH-1:0] expire_time_next;
  logic [TIME_WIDTH-1:0] next_try_time_next;
  logic [7:0]            try_count_next;
  logic                  is_finite_next;

  logic [6:0]            pct_c;
  logic [9:0]            pct10;
  logic [7:0]            cnt_inc_c;
  logic [SHIFT_W-1:0]    shift;
  logic [DELAY_W-1:0]    shifted;
  logic [DELAY_W-1:0]    cap_w;

  always_comb begin
    pct_c     = (cfg.renew_percent > PCT_FULL) ? PCT_FULL : cfg.renew_percent;
    pct10     = 10'(pct_c) * 10'(PCT_SCALE);
    cnt_inc_c = (try_count == COUNT_MAX) ? COUNT_MAX : try_count + 8'd1;
    shift     = (cnt_inc_c > 8'(MAX_SHIFT)) ? MAX_SHIFT : SHIFT_W'(cnt_inc_c - 8'd1);
    shifted   = DELAY_W'(cfg.retry_base_ms) << shift;
    cap_w     = DELAY_W'(cfg.retry_cap_ms);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q  <= command;
      now_q  <= now_ms[TIME_WIDTH-1:0];
      life_q <= lease_life_s;
    end
    if (cmd.mul_en) begin
      life_ms   <= OFF_W'(life_q) * OFF_W'(MS_PER_S);
      renew_off <= OFF_W'(life_q) * OFF_W'(pct10);
      delay     <= (shifted > cap_w) ? cap_w : shifted;
      cnt_inc   <= cnt_inc_c;
    end
    if (cmd.add_en) begin
      renew_sum  <= sat_add(now_q, renew_off);
      expire_sum <= sat_add(now_q, life_ms);
      try_sum    <= sat_add(now_q, OFF_W'(delay));
    end
  end

  always_comb begin
    expire_time_next   = expire_time;
    next_try_time_next = next_try_time;
    try_count_next     = try_count;
    is_finite_next     = is_finite;
    unique case (command_t'(cmd_q))
      CMD_QUERY: begin
      end
      CMD_ACTIVATE: begin
        try_count_next = 8'd0;
        if (life_q == 32'd0) begin
          expire_time_next   = TMAX;
          next_try_time_next = TMAX;
          is_finite_next     = 1'b0;
        end else begin
          expire_time_next   = expire_sum;
          next_try_time_next = renew_sum;
          is_finite_next     = 1'b1;
        end
      end
      CMD_MARK: begin
        if (is_finite) begin
          try_count_next     = cnt_inc;
          next_try_time_next = (try_sum > expire_time) ? expire_time : try_sum;
        end
      end
      CMD_CLEAR: begin
        expire_time_next   = '0;
        next_try_time_next = '0;
        try_count_next     = 8'd0;
        is_finite_next     = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expire_time   <= '0;
      next_try_time <= '0;
      try_count     <= 8'd0;
      is_finite     <= 1'b0;
    end else if (cmd.commit) begin
      expire_time   <= expire_time_next;
      next_try_time <= next_try_time_next;
      try_count     <= try_count_next;
      is_finite     <= is_finite_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      attempt_due       <= is_finite_next && (now_q >= next_try_time_next) &&
                           (now_q < expire_time_next);
      lease_expired     <= is_finite_next && (now_q >= expire_time_next);
      lease_finite      <= is_finite_next;
      next_attempt_time <= 64'(next_try_time_next);
      expiry_time       <= 64'(expire_time_next);
      attempts_made     <= try_count_next;
    end
  end

endmodule

// File: design/lease_renewal_backoff_timer.sv
// Lease renewal timer with capped exponential retry backoff.
// Input channel (in_valid/in_ready) carries one event beat: command (query,
// activate, mark attempt, clear), now_ms and lease_life_s. Output channel
// (out_valid/out_ready) returns one result beat per event: attempt_due,
// lease_expired, lease_finite, next_attempt_time, expiry_time, attempts_made,
// all describing the state after the event, judged at now_ms.
// Each accepted event steps through multiply, saturating add and commit
// before its result is valid. The controller walks one event through the
// shared datapath at a time, so a new event waits until the last commits.
// The result sits in an output register; a new event is accepted while it
// waits. If the receiver stalls, the following event holds at commit until
// the output register frees, and in_ready stays low meanwhile.
// Configuration is an APB-style port: renew_percent at 0x0, retry_base_ms at
// 0x4, retry_cap_ms at 0x8; write only while no event is in flight.
// Reset (rst, synchronous) clears the lease state to idle, drops out_valid,
// raises in_ready and loads the register defaults 45, 30000 and 300000.
module lease_renewal_backoff_timer import lbt_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [63:0] now_ms,
  input  logic [31:0] lease_life_s,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        attempt_due,
  output logic        lease_expired,
  output logic        lease_finite,
  output logic [63:0] next_attempt_time,
  output logic [63:0] expiry_time,
  output logic [7:0]  attempts_made,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg;
  ctl_cmd_t cmd;
  logic     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.renew_percent <= RENEW_PCT_RST;
      cfg.retry_base_ms <= RETRY_BASE_RST;
      cfg.retry_cap_ms  <= RETRY_CAP_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_RENEW_PCT:  cfg.renew_percent <= pwdata[6:0];
        REG_RETRY_BASE: cfg.retry_base_ms <= pwdata;
        REG_RETRY_CAP:  cfg.retry_cap_ms  <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RENEW_PCT:  prdata = 32'(cfg.renew_percent);
      REG_RETRY_BASE: prdata = cfg.retry_base_ms;
      REG_RETRY_CAP:  prdata = cfg.retry_cap_ms;
      default:        prdata = 32'd0;
    endcase
  end

  lbt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lbt_datapath #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .cfg               (cfg),
    .command           (command),
    .now_ms            (now_ms),
    .lease_life_s      (lease_life_s),
    .attempt_due       (attempt_due),
    .lease_expired     (lease_expired),
    .lease_finite      (lease_finite),
    .next_attempt_time (next_attempt_time),
    .expiry_time       (expiry_time),
    .attempts_made     (attempts_made)
  );

endmodule

// File: design/lbt_checker.sv
module lbt_checker import lbt_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        attempt_due,
  input logic        lease_expired,
  input logic        lease_finite,
  input logic [63:0] next_attempt_time,
  input logic [63:0] expiry_time,
  input logic [7:0]  attempts_made
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_attempt_time))
    else $error("result beat dropped or changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second event accepted while one is in flight");

  a_due_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && attempt_due |-> lease_finite && !lease_expired)
    else $error("attempt due on expired or infinite lease");

  a_count_finite: assert property (@(posedge clk) disable iff (rst)
    out_valid && (attempts_made != 8'd0) |-> lease_finite)
    else $error("attempts counted without a finite lease");

  a_try_before_expiry: assert property (@(posedge clk) disable iff (rst)
    out_valid && lease_finite |-> next_attempt_time <= expiry_time)
    else $error("next attempt scheduled past expiry");

endmodule

bind lease_renewal_backoff_timer lbt_checker u_lbt_checker (.*);
